FILE: src/akc_pkg.sv
// shared types, constants and helpers for the arx keystream cipher
// no dependencies
package akc_pkg;

  localparam int DATA_W      = 8;
  localparam int WORD_W      = 64;
  localparam int POS_W       = 5;
  localparam int KS_W        = 256;
  localparam int ROUND_W     = 3;
  localparam int CFG_AW      = 3;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [WORD_W-1:0] GOLDEN_WORD = 64'h9e3779b97f4a7c15;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 3'd7;

  localparam logic [CFG_AW-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_3 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SITE  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DIV   = 3'd5;

  localparam logic [5:0] ROT_AMT [4][4] = '{
    '{6'd32, 6'd24, 6'd16, 6'd63},
    '{6'd31, 6'd17, 6'd47, 6'd23},
    '{6'd13, 6'd37, 6'd29, 6'd43},
    '{6'd7,  6'd19, 6'd41, 6'd53}
  };

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] key0;
    logic [WORD_W-1:0] key1;
    logic [WORD_W-1:0] key2;
    logic [WORD_W-1:0] key3;
    logic [WORD_W-1:0] site;
    logic [WORD_W-1:0] div;
  } key_cfg_t;

  typedef struct packed {
    logic              start;
    logic              abort;
    logic [WORD_W-1:0] ctr;
  } gen_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_sts_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [1:0] set_sel,
                                             input logic [1:0] slot);
    logic [5:0] n;
    n = ROT_AMT[set_sel][slot];
    return (x << n) | (x >> (7'd64 - {1'b0, n}));
  endfunction

endpackage

FILE: src/arx_keystream_cipher.sv
// Byte-stream XOR cipher. Each input transaction carries one byte and leaves as one output
// transaction, in order, at up to one byte per cycle. The byte at block position 0 takes a
// fresh 32-byte keystream block, built from the key, site, diversifier and block counter by
// one ARX unit that does half a round per cycle: it loads its state, runs eight rounds and
// hands the block over. The next block is built ahead while the current one is in use, and
// the first block of a message is kept, so back-to-back short messages and long messages
// both run at one byte per cycle. The first byte of a block waits at the head of the queue
// only when no block is ready: the first after reset or after a register write, and the
// first of a message after a mid-message write. The user is to make register writes only
// while the block is idle; this is not enforced. tlast ends a message and restarts the
// counter and position. Writes to indexes 6 and 7 set no register but drop the prefetch.
// depends on akc_pkg, akc_front, akc_keygen, akc_back
module arx_keystream_cipher
  import akc_pkg::*;
#(
  parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // data_in
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // data_out
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [WORD_W-1:0] cfg_wdata
);

  key_cfg_t        cfg_r;
  logic            head_valid, pop;
  item_t           head;
  gen_ctl_t        gen_ctl;
  gen_sts_t        gen_sts;
  logic [KS_W-1:0] gen_ks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_0: cfg_r.key0 <= cfg_wdata;
        REG_KEY_1: cfg_r.key1 <= cfg_wdata;
        REG_KEY_2: cfg_r.key2 <= cfg_wdata;
        REG_KEY_3: cfg_r.key3 <= cfg_wdata;
        REG_SITE:  cfg_r.site <= cfg_wdata;
        REG_DIV:   cfg_r.div  <= cfg_wdata;
        default:   cfg_r      <= cfg_r;
      endcase
    end
  end

  akc_front #(
    .DEPTH(FIFO_DEPTH_P)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  akc_keygen u_keygen (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg_r),
    .ctl  (gen_ctl),
    .sts  (gen_sts),
    .ks   (gen_ks)
  );

  akc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_we),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .gen_ctl   (gen_ctl),
    .gen_sts   (gen_sts),
    .gen_ks    (gen_ks),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

FILE: src/akc_front.sv
// input side: takes byte transactions, tags each with its block position, queues them
// depends on akc_pkg
module akc_front
  import akc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tlast,
  output logic              head_valid,
  output item_t             head,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             push;
  logic             do_pop;

  assign in_tready  = (cnt_r != CNT_FULL);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign pos_nxt    = in_tlast ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= '{data: in_tdata, last: in_tlast, pos: pos_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
        pos_r    <= pos_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: src/akc_keygen.sv
// arx keystream generator: loads its state, then builds one 32-byte block in eight rounds,
// half a round per cycle
// depends on akc_pkg
module akc_keygen
  import akc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  key_cfg_t        cfg,
  input  gen_ctl_t        ctl,
  output gen_sts_t        sts,
  output logic [KS_W-1:0] ks
);

  logic [WORD_W-1:0]  a_r, b_r, c_r, d_r, ctr_r;
  logic [WORD_W-1:0]  a1, b1, c1, d1, a2, c2;
  logic [ROUND_W-1:0] rnd_r;
  logic               half_r, busy_r, done_r;
  logic [1:0]         rs, slot0, slot1;
  logic               final_step;

  assign rs         = cfg.div[1:0] ^ ctr_r[1:0] ^ rnd_r[1:0];
  assign slot0      = half_r ? 2'd2 : 2'd0;
  assign slot1      = half_r ? 2'd3 : 2'd1;
  assign final_step = half_r && (rnd_r == LAST_ROUND);

  always_comb begin
    a1 = a_r + b_r;
    d1 = rotl(d_r ^ a1, rs, slot0);
    c1 = c_r + d1;
    b1 = rotl(b_r ^ c1, rs, slot1);
    a2 = a1;
    c2 = c1;
    if (half_r) begin
      a2 = a1 ^ (GOLDEN_WORD + {{(WORD_W-ROUND_W){1'b0}}, rnd_r});
      c2 = c1 ^ (ctr_r + {{(WORD_W-ROUND_W){1'b0}}, rnd_r});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= cfg.key0 ^ cfg.site;
      b_r   <= cfg.key1 ^ cfg.div;
      c_r   <= cfg.key2 ^ ctl.ctr;
      d_r   <= cfg.key3 ^ GOLDEN_WORD;
      ctr_r <= ctl.ctr;
    end else if (busy_r) begin
      a_r <= a2;
      b_r <= b1;
      c_r <= c2;
      d_r <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      half_r <= 1'b0;
    end else begin
      done_r <= busy_r && final_step && !ctl.abort;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        half_r <= 1'b0;
      end else if (busy_r) begin
        half_r <= !half_r;
        if (half_r) begin
          rnd_r <= rnd_r + 1'b1;
        end
        if (final_step || ctl.abort) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign ks  = {d_r, c_r, b_r, a_r};

endmodule

FILE: src/akc_back.sv
// output side: block counter, prefetched keystream blocks, byte xor and output register
// depends on akc_pkg
module akc_back
  import akc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic              head_valid,
  input  item_t             head,
  output logic              pop,
  output gen_ctl_t          gen_ctl,
  input  gen_sts_t          gen_sts,
  input  logic [KS_W-1:0]   gen_ks,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic [KS_W-1:0]   cur_ks_r, pre_ks_r, zero_ks_r;
  logic              pre_valid_r, zero_valid_r;
  logic [WORD_W-1:0] ctr_r;
  logic              out_valid_r, out_last_r;
  logic [DATA_W-1:0] out_data_r;
  logic              need_ks, can_out, clear;
  logic [DATA_W-1:0] ks_byte;

  assign need_ks = (head.pos == '0);
  assign can_out = !out_valid_r || out_tready;
  assign pop     = head_valid && can_out && (!need_ks || pre_valid_r);
  assign ks_byte = need_ks ? pre_ks_r[DATA_W-1:0] : cur_ks_r[{head.pos, 3'b000} +: DATA_W];
  assign clear   = (pop && head.last) || cfg_wr;

  assign gen_ctl.start = !pre_valid_r && !gen_sts.busy && !gen_sts.done && !clear;
  assign gen_ctl.abort = clear;
  assign gen_ctl.ctr   = ctr_r;

  always_ff @(posedge clk) begin
    if (pop && need_ks) begin
      cur_ks_r <= pre_ks_r;
    end
    if (can_out && pop) begin
      out_data_r <= head.data ^ ks_byte;
      out_last_r <= head.last;
    end
    if (!cfg_wr) begin
      if (pop && head.last) begin
        pre_ks_r <= zero_ks_r;
      end else if (!(pop && need_ks) && gen_sts.done) begin
        pre_ks_r <= gen_ks;
        if (ctr_r == '0) begin
          zero_ks_r <= gen_ks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pre_valid_r  <= 1'b0;
      zero_valid_r <= 1'b0;
      ctr_r        <= '0;
    end else begin
      if (can_out) begin
        out_valid_r <= pop;
      end
      if (pop && head.last) begin
        ctr_r <= '0;
      end else if (pop && need_ks) begin
        ctr_r <= ctr_r + 1'b1;
      end
      if (cfg_wr) begin
        pre_valid_r  <= 1'b0;
        zero_valid_r <= 1'b0;
      end else if (pop && head.last) begin
        pre_valid_r <= zero_valid_r;
      end else if (pop && need_ks) begin
        pre_valid_r <= 1'b0;
      end else if (gen_sts.done) begin
        pre_valid_r <= 1'b1;
        if (ctr_r == '0) begin
          zero_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
